>>> hdl/assert_macros.svh
// Assertion macros for the checker file of this block.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Concurrent check on clk, switched off while rst_n is low
`define SWM_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Concurrent check on clk that also holds through reset
`define SWM_ASSERT_NORST(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

>>> hdl/swm_pkg.sv
// Shared types and constants of the sliding-window median filter.
package swm_pkg;

    // Fixed field widths
    localparam int SAMPLE_W  = 32;
    localparam int LEN_W     = 6;
    localparam int PDATA_W   = 32;
    localparam int PADDR_W   = 3;

    // Register map (word index in paddr above the byte offset)
    localparam logic [PADDR_W-3:0] REG_WINDOW_LENGTH = 1'b0;
    localparam logic [LEN_W-1:0]   LEN_RESET         = 6'd1;

    typedef logic signed [SAMPLE_W-1:0] sample_t;

    // Commands from the control side to the sorted cell array
    typedef struct packed {
        logic insert;   // take the staged sample this cycle
        logic purge;    // drop one surplus oldest entry this cycle
    } swm_cmd_t;

    // Status from the cell array back to the control side
    typedef struct packed {
        logic result;   // this insert yields a median
        logic cleaning; // surplus entries still to drop
    } swm_status_t;

endpackage

>>> hdl/swm_cells.sv
// Sorted cell array: parallel insertion, median pick and oldest-entry removal.
module swm_cells
    import swm_pkg::*;
#(
    parameter int WINDOW_MAX = 32
) (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  swm_cmd_t                              cmd,
    input  sample_t                               sample,
    input  logic [$clog2(WINDOW_MAX+1)-1:0]       win_len,
    output swm_status_t                           status,
    output sample_t                               median
);

    localparam int CW = $clog2(WINDOW_MAX + 1);
    localparam int AW = (WINDOW_MAX > 1) ? $clog2(WINDOW_MAX) : 1;

    // Cell storage, kept in ascending order; ages tell arrival order
    sample_t         val_reg [WINDOW_MAX];
    logic [AW-1:0]   age_reg [WINDOW_MAX];
    logic [CW-1:0]   fill_reg;
    logic [CW-1:0]   fill_next;
    logic [CW-1:0]   clean_len_reg;
    logic            cleaning_reg;
    logic            cleaning_next;

    sample_t         ins_val [WINDOW_MAX];
    logic [AW-1:0]   ins_age [WINDOW_MAX];
    sample_t         del_val [WINDOW_MAX];
    logic [AW-1:0]   del_age [WINDOW_MAX];

    logic [WINDOW_MAX-1:0] below;
    logic [WINDOW_MAX-1:0] take_new;
    logic [WINDOW_MAX-1:0] hit;
    logic [WINDOW_MAX-1:0] after;

    logic            active;
    logic [CW-1:0]   len;
    logic [CW-1:0]   count_a;
    logic [CW-1:0]   oldest_cnt;
    logic [AW-1:0]   oldest_age;
    logic [CW-1:0]   mid_wide;
    logic [AW-1:0]   mid_idx;
    logic            drop;

    assign active     = cmd.insert | cmd.purge;
    assign len        = cmd.insert ? win_len : clean_len_reg;
    assign count_a    = cmd.insert ? (fill_reg + 1'b1) : fill_reg;
    assign drop       = active && (count_a >= len);
    assign oldest_cnt = count_a - 1'b1;
    assign oldest_age = oldest_cnt[AW-1:0];

    genvar i;
    generate
        for (i = 0; i < WINDOW_MAX; i++) begin : g_cell
            // Entries not above the new sample stay; equal values keep arrival order
            assign below[i] = (CW'(i) < fill_reg) && (val_reg[i] <= sample);

            if (i == 0) begin : g_first
                assign take_new[i] = !below[i];
                assign ins_val[i]  = (!cmd.insert || below[i]) ? val_reg[i] : sample;
                assign ins_age[i]  = !cmd.insert ? age_reg[i] :
                                     below[i]    ? (age_reg[i] + 1'b1) : '0;
            end
            else begin : g_rest
                assign take_new[i] = !below[i] && below[i-1];
                assign ins_val[i]  = !cmd.insert ? val_reg[i]   :
                                     below[i]    ? val_reg[i]   :
                                     take_new[i] ? sample       : val_reg[i-1];
                assign ins_age[i]  = !cmd.insert ? age_reg[i]            :
                                     below[i]    ? (age_reg[i] + 1'b1)   :
                                     take_new[i] ? '0                    :
                                                   (age_reg[i-1] + 1'b1);
            end

            // Locate the oldest entry and close the gap it leaves
            assign hit[i]   = (CW'(i) < count_a) && (ins_age[i] == oldest_age);
            assign after[i] = |hit[i:0];

            if (i < WINDOW_MAX - 1) begin : g_shift
                assign del_val[i] = (drop && after[i]) ? ins_val[i+1] : ins_val[i];
                assign del_age[i] = (drop && after[i]) ? ins_age[i+1] : ins_age[i];
            end
            else begin : g_last
                assign del_val[i] = ins_val[i];
                assign del_age[i] = ins_age[i];
            end
        end
    endgenerate

    // Lower median: rank floor((len-1)/2) of the window after insertion
    assign mid_wide = (len - 1'b1) >> 1;
    assign mid_idx  = mid_wide[AW-1:0];
    assign median   = ins_val[mid_idx];

    assign fill_next     = count_a - CW'(drop);
    assign cleaning_next = drop && (fill_next >= len);

    assign status.result   = cmd.insert && drop;
    assign status.cleaning = cleaning_reg;

    // Cell contents
    always_ff @(posedge clk)
    begin
        if (active)
        begin
            for (int k = 0; k < WINDOW_MAX; k++)
            begin
                val_reg[k] <= del_val[k];
                age_reg[k] <= del_age[k];
            end
        end
    end

    // Fill count and purge tracking
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fill_reg      <= '0;
            clean_len_reg <= '0;
            cleaning_reg  <= 1'b0;
        end
        else if (active)
        begin
            fill_reg      <= fill_next;
            clean_len_reg <= len;
            cleaning_reg  <= cleaning_next;
        end
    end

endmodule

>>> hdl/sliding_window_median.sv
// Sliding-window lower-median filter. Takes one signed 32-bit sample per clock
// in steady state, while out_ready is high and no purge runs. A sample is held
// in the input register and, once it advances, passes through the sorted cell
// array into the output register, which drives the median port. Every cell
// compares against the new sample in parallel, so insertion, median pick and
// removal of the oldest entry finish together as the word advances. No median is
// given until window_length samples have been seen. A median word held by
// out_ready low stops the staged word, and in_ready drops once the input register
// is full. After window_length is lowered, the first median is picked at the new
// length's rank from the older, larger window; the surplus oldest entries are
// then dropped one per cycle while the staged word waits, with in_ready low once
// the input register holds a word.
module sliding_window_median
    import swm_pkg::*;
#(
    parameter int WINDOW_MAX = 32
) (
    input  logic                 clk,
    input  logic                 rst_n,
    // sample stream
    input  logic                 in_valid,
    output logic                 in_ready,
    input  sample_t              sample,
    // median stream
    output logic                 out_valid,
    input  logic                 out_ready,
    output sample_t              median,
    // configuration
    input  logic                 psel,
    input  logic                 penable,
    input  logic                 pwrite,
    input  logic [PADDR_W-1:0]   paddr,
    input  logic [PDATA_W-1:0]   pwdata,
    output logic [PDATA_W-1:0]   prdata,
    output logic                 pready
);

    localparam int CW = $clog2(WINDOW_MAX + 1);

    logic [LEN_W-1:0] window_length_reg;
    logic [CW-1:0]    win_len;
    logic             reg_sel;

    logic             in_valid_reg;
    sample_t          sample_reg;
    logic             out_valid_reg;
    sample_t          median_reg;

    logic             advance;
    swm_cmd_t         cmd;
    swm_status_t      status;
    sample_t          cell_median;

    // Register access
    assign pready  = 1'b1;
    assign reg_sel = (paddr[PADDR_W-1:2] == REG_WINDOW_LENGTH);
    assign prdata  = reg_sel ? PDATA_W'(window_length_reg) : '0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            window_length_reg <= LEN_RESET;
        else if (psel && penable && pwrite && pready && reg_sel)
            window_length_reg <= pwdata[LEN_W-1:0];
    end

    // Effective length: zero acts as one, clamp at WINDOW_MAX
    always_comb
    begin
        if (window_length_reg == '0)
            win_len = CW'(1);
        else if (32'(window_length_reg) > WINDOW_MAX)
            win_len = CW'(WINDOW_MAX);
        else
            win_len = CW'(window_length_reg);
    end

    // Handshake: staged word moves on when no purge runs and the output slot frees
    assign advance  = in_valid_reg && !status.cleaning && (!out_valid_reg || out_ready);
    assign in_ready = !in_valid_reg || advance;

    assign cmd.insert = advance;
    assign cmd.purge  = status.cleaning;

    // Input register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            in_valid_reg <= 1'b0;
        else if (in_ready)
            in_valid_reg <= in_valid;
    end

    always_ff @(posedge clk)
    begin
        if (in_ready && in_valid)
            sample_reg <= sample;
    end

    swm_cells #(
        .WINDOW_MAX (WINDOW_MAX)
    ) u_cells (
        .clk     (clk),
        .rst_n   (rst_n),
        .cmd     (cmd),
        .sample  (sample_reg),
        .win_len (win_len),
        .status  (status),
        .median  (cell_median)
    );

    // Output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (advance && status.result)
            out_valid_reg <= 1'b1;
        else if (out_ready)
            out_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (advance && status.result)
            median_reg <= cell_median;
    end

    assign out_valid = out_valid_reg;
    assign median    = median_reg;

endmodule

>>> hdl/swm_checker.sv
// Port-level checks of the sliding-window median filter, bound to the top level.
`include "assert_macros.svh"

module swm_checker
    import swm_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    input  logic                 in_ready,
    input  sample_t              sample,
    input  logic                 out_valid,
    input  logic                 out_ready,
    input  sample_t              median,
    input  logic                 psel,
    input  logic                 penable,
    input  logic                 pwrite,
    input  logic [PADDR_W-1:0]   paddr,
    input  logic [PDATA_W-1:0]   pwdata,
    input  logic [PDATA_W-1:0]   prdata,
    input  logic                 pready
);

    // A stalled median word holds
    `SWM_ASSERT(a_out_hold, out_valid && !out_ready |=> out_valid && $stable(median), "median word changed while stalled")

    // Only the length bits are ever read back
    `SWM_ASSERT(a_prdata_upper, psel |-> prdata[PDATA_W-1:LEN_W] == '0, "upper read bits not zero")

    // A length write is visible to a read in the next cycle
    `SWM_ASSERT(a_len_readback, (psel && penable && pwrite && pready && !paddr[2]) ##1 (psel && !pwrite && !paddr[2]) |-> prdata[LEN_W-1:0] == $past(pwdata[LEN_W-1:0]), "window_length read-back mismatch")

    // No median straight out of reset
    `SWM_ASSERT_NORST(a_reset_quiet, !$past(rst_n) |-> !out_valid, "median valid right after reset")

endmodule

bind sliding_window_median swm_checker u_swm_checker (.*);
